// ----- rtl/ors_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_pkg
// shared types and constants of the rom search engine
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int unsigned ROM_BITS     = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned FAM_W        = 4;
  localparam int unsigned FAMILY_LIMIT = 9;
  localparam int unsigned S_DATA_W     = 8;
  localparam int unsigned M_DATA_W     = 72;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PAIR  = 2'd2;

  typedef enum logic [2:0] {
    KIND_DIR     = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_ABORT   = 3'd2,
    KIND_STARTED = 3'd3,
    KIND_NO_PASS = 3'd4,
    KIND_CLEARED = 3'd5,
    KIND_IGNORED = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic                direction;
    logic                found;
    logic [ROM_BITS-1:0] rom_address;
    logic [FAM_W-1:0]    family_discrepancy;
  } result_t;

  typedef struct packed {
    logic             pass_active;
    logic [POS_W-1:0] bit_position;
  } status_t;

endpackage

// ----- rtl/ors_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_step
// search state registers and the per-word update of one rom search step
// ----------------------------------------------------------------------------
module ors_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ors_pkg::item_t   item,
  output ors_pkg::result_t result,
  output ors_pkg::status_t status
);
  import ors_pkg::*;

  logic [ROM_BITS-1:0] rom_image, rom_image_next;
  logic [POS_W-1:0]    last_discrepancy, last_discrepancy_next;
  logic [FAM_W-1:0]    last_family_discrepancy, last_family_discrepancy_next;
  logic                last_device_seen, last_device_seen_next;
  logic [POS_W-1:0]    bit_position, bit_position_next;
  logic [POS_W-1:0]    last_zero_branch, last_zero_branch_next;
  logic                pass_active, pass_active_next;

  logic [POS_W-1:0]                pos;
  logic [$clog2(ROM_BITS)-1:0]     idx;
  logic                            dir;
  logic                            branch_zero;
  logic [ROM_BITS-1:0]             rom_upd;
  logic [POS_W-1:0]                lzb_upd;
  logic [FAM_W-1:0]                lfd_upd;

  // position guarded into 1..64
  assign pos = (bit_position == '0 || bit_position > POS_W'(ROM_BITS))
               ? POS_W'(1) : bit_position;
  assign idx = pos[$clog2(ROM_BITS)-1:0] - 1'b1;

  always_comb begin
    if (item.id_bit != item.complement_bit) begin
      dir = item.id_bit;
    end else if (pos < last_discrepancy) begin
      dir = rom_image[idx];
    end else begin
      dir = (pos == last_discrepancy);
    end
    branch_zero = (item.id_bit == item.complement_bit) && !dir;
    lzb_upd = branch_zero ? pos : last_zero_branch;
    lfd_upd = (branch_zero && pos < POS_W'(FAMILY_LIMIT))
              ? pos[FAM_W-1:0] : last_family_discrepancy;
    rom_upd = rom_image;
    rom_upd[idx] = dir;
  end

  always_comb begin
    rom_image_next               = rom_image;
    last_discrepancy_next        = last_discrepancy;
    last_family_discrepancy_next = last_family_discrepancy;
    last_device_seen_next        = last_device_seen;
    bit_position_next            = bit_position;
    last_zero_branch_next        = last_zero_branch;
    pass_active_next             = pass_active;
    result.kind                  = KIND_IGNORED;
    result.direction             = 1'b0;
    result.found                 = 1'b0;
    case (item.operation)
      OP_CLEAR: begin
        rom_image_next               = '0;
        last_discrepancy_next        = '0;
        last_family_discrepancy_next = '0;
        last_device_seen_next        = 1'b0;
        bit_position_next            = POS_W'(1);
        last_zero_branch_next        = '0;
        pass_active_next             = 1'b0;
        result.kind                  = KIND_CLEARED;
      end
      OP_START: begin
        bit_position_next = POS_W'(1);
        if (last_device_seen || !item.presence) begin
          last_discrepancy_next        = '0;
          last_family_discrepancy_next = '0;
          last_device_seen_next        = 1'b0;
          pass_active_next             = 1'b0;
          result.kind                  = KIND_NO_PASS;
        end else begin
          pass_active_next      = 1'b1;
          last_zero_branch_next = '0;
          result.kind           = KIND_STARTED;
        end
      end
      OP_PAIR: begin
        if (pass_active) begin
          if (item.id_bit && item.complement_bit) begin
            last_discrepancy_next        = '0;
            last_family_discrepancy_next = '0;
            last_device_seen_next        = 1'b0;
            pass_active_next             = 1'b0;
            bit_position_next            = POS_W'(1);
            result.kind                  = KIND_ABORT;
          end else begin
            result.direction             = dir;
            rom_image_next               = rom_upd;
            last_zero_branch_next        = lzb_upd;
            last_family_discrepancy_next = lfd_upd;
            if (pos == POS_W'(ROM_BITS)) begin
              pass_active_next  = 1'b0;
              bit_position_next = POS_W'(1);
              result.kind       = KIND_DONE;
              // a zero family byte means no real device answered
              if (rom_upd[7:0] == 8'd0) begin
                last_discrepancy_next        = '0;
                last_family_discrepancy_next = '0;
                last_device_seen_next        = 1'b0;
              end else begin
                last_discrepancy_next = lzb_upd;
                last_device_seen_next = (lzb_upd == '0);
                result.found          = 1'b1;
              end
            end else begin
              bit_position_next = pos + 1'b1;
              result.kind       = KIND_DIR;
            end
          end
        end
      end
      default: begin
        result.kind = KIND_IGNORED;
      end
    endcase
    result.rom_address        = rom_image_next;
    result.family_discrepancy = last_family_discrepancy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_image               <= '0;
      last_discrepancy        <= '0;
      last_family_discrepancy <= '0;
      last_device_seen        <= 1'b0;
      bit_position            <= POS_W'(1);
      last_zero_branch        <= '0;
      pass_active             <= 1'b0;
    end else if (en) begin
      rom_image               <= rom_image_next;
      last_discrepancy        <= last_discrepancy_next;
      last_family_discrepancy <= last_family_discrepancy_next;
      last_device_seen        <= last_device_seen_next;
      bit_position            <= bit_position_next;
      last_zero_branch        <= last_zero_branch_next;
      pass_active             <= pass_active_next;
    end
  end

  assign status.pass_active  = pass_active;
  assign status.bit_position = bit_position;

endmodule

// ----- rtl/onewire_rom_search_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_rom_search_engine_top
// bit-level rom search engine with registered input and result stages
// ----------------------------------------------------------------------------
// Takes one word per clock while the result side keeps up: clear, start pass
// (with the presence result) or a bit pair read from the bus, and returns
// exactly one result word for each, carrying the bit to write back, the pass
// outcome, the current rom image and the last family discrepancy. A word is
// held in the input register, where the search-state update reads it, and
// lands in the result register when the pipeline advances. The sustained rate
// is one word per cycle while the result side accepts, and the state update
// loop sets that rate. A stalled result register holds the pipeline, and input
// is then taken only while the input register is empty.
module onewire_rom_search_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] presence, [1] id_bit, [2] complement_bit, [7:3] zero
  input  logic [ors_pkg::S_DATA_W-1:0]  s_tdata,
  // [1:0] operation
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] direction, [1] found, [65:2] rom_address, [69:66] family_discrepancy,
  // [71:70] zero
  output logic [ors_pkg::M_DATA_W-1:0]  m_tdata,
  // [2:0] kind
  output logic [2:0]                    m_tuser
);
  import ors_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t step_result;
  result_t out_result;
  status_t status;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.operation      <= s_tuser;
      in_item.presence       <= s_tdata[0];
      in_item.id_bit         <= s_tdata[1];
      in_item.complement_bit <= s_tdata[2];
    end
  end

  ors_step u_step (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .result (step_result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tuser = out_result.kind;
  assign m_tdata = {2'b00, out_result.family_discrepancy, out_result.rom_address,
                    out_result.found, out_result.direction};

  // a processed word always lands in the result register
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed word missing from result register");

  a_found_only_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.found) |-> (out_result.kind == KIND_DONE))
    else $error("found flagged outside pass completion");

  a_dir_only_pair: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.direction) |->
      (out_result.kind == KIND_DIR || out_result.kind == KIND_DONE))
    else $error("direction set on a non bit-pair result");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    status.pass_active |->
      (status.bit_position != '0 && status.bit_position <= POS_W'(ROM_BITS)))
    else $error("bit position out of range during a pass");

endmodule

// ----- verif/onewire_rom_search_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_rom_search_checker
// watches both streams of the rom search engine, predicts each result word
// from its own copy of the search state and compares it field by field
// ----------------------------------------------------------------------------
module onewire_rom_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [0] presence, [1] id_bit, [2] complement_bit, [7:3] zero
  input  logic [7:0]  s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [0] direction, [1] found, [65:2] rom_address, [69:66] family_discrepancy,
  // [71:70] zero
  input  logic [71:0] m_tdata,
  // [2:0] kind
  input  logic [2:0]  m_tuser,
  output int unsigned error_count,
  output int unsigned outstanding
);
  import ors_pkg::*;

  // search state as the engine should hold it
  logic [ROM_BITS-1:0] rom_image;
  logic [POS_W-1:0]    last_disc;
  logic [FAM_W-1:0]    family_disc;
  logic                device_seen;
  logic [POS_W-1:0]    bit_pos;
  logic [POS_W-1:0]    zero_branch;
  logic                in_pass;

  result_t expected_results[$];
  item_t   in_word;
  result_t want;
  result_t got;

  function automatic void drop_counters();
    last_disc   = '0;
    family_disc = '0;
    device_seen = 1'b0;
  endfunction

  function automatic void restart_search();
    rom_image   = '0;
    drop_counters();
    bit_pos     = 7'd1;
    zero_branch = '0;
    in_pass     = 1'b0;
  endfunction

  // one step of the rom search: returns the result word for one input word
  function automatic result_t advance_search(input item_t w);
    result_t                     r;
    logic                        dir;
    logic                        dev_found;
    kind_t                       k;
    logic [POS_W-1:0]            pos;
    logic [$clog2(ROM_BITS)-1:0] bit_idx;
    dir       = 1'b0;
    dev_found = 1'b0;
    k         = KIND_IGNORED;
    case (w.operation)
      OP_CLEAR: begin
        restart_search();
        k = KIND_CLEARED;
      end
      OP_START: begin
        if (device_seen || !w.presence) begin
          drop_counters();
          in_pass = 1'b0;
          bit_pos = 7'd1;
          k       = KIND_NO_PASS;
        end else begin
          in_pass     = 1'b1;
          bit_pos     = 7'd1;
          zero_branch = '0;
          k           = KIND_STARTED;
        end
      end
      OP_PAIR: begin
        if (in_pass) begin
          if (bit_pos < 1 || bit_pos > ROM_BITS) bit_pos = 7'd1;
          if (w.id_bit && w.complement_bit) begin
            // no device answered either value
            drop_counters();
            in_pass = 1'b0;
            bit_pos = 7'd1;
            k       = KIND_ABORT;
          end else begin
            pos     = bit_pos;
            bit_idx = pos[$clog2(ROM_BITS)-1:0] - 1'b1;
            if (w.id_bit != w.complement_bit) begin
              dir = w.id_bit;
            end else begin
              // discrepancy: prior path before last_disc, 1 at it, 0 after
              if (pos < last_disc) dir = rom_image[bit_idx];
              else dir = (pos == last_disc);
              if (!dir) begin
                zero_branch = pos;
                if (pos < FAMILY_LIMIT) family_disc = pos[FAM_W-1:0];
              end
            end
            rom_image[bit_idx] = dir;
            if (pos == ROM_BITS) begin
              last_disc = zero_branch;
              if (last_disc == '0) device_seen = 1'b1;
              dev_found = 1'b1;
              if (rom_image[7:0] == 8'h00) begin
                drop_counters();
                dev_found = 1'b0;
              end
              in_pass = 1'b0;
              bit_pos = 7'd1;
              k       = KIND_DONE;
            end else begin
              bit_pos = pos + 7'd1;
              k       = KIND_DIR;
            end
          end
        end
      end
      default: ;
    endcase
    r.kind               = k;
    r.direction          = dir;
    r.found              = dev_found;
    r.rom_address        = rom_image;
    r.family_discrepancy = family_disc;
    return r;
  endfunction

  function automatic bit field_differs(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_search();
      expected_results.delete();
      error_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind               = kind_t'(m_tuser);
        got.direction          = m_tdata[0];
        got.found              = m_tdata[1];
        got.rom_address        = m_tdata[65:2];
        got.family_discrepancy = m_tdata[69:66];
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, got);
        end else begin
          want = expected_results.pop_front();
          if (field_differs("kind", want.kind, got.kind) |
              field_differs("direction", want.direction, got.direction) |
              field_differs("found", want.found, got.found) |
              field_differs("rom_address", want.rom_address, got.rom_address) |
              field_differs("family_discrepancy", want.family_discrepancy,
                            got.family_discrepancy))
            error_count++;
        end
      end
      if (s_tvalid && s_tready) begin
        in_word.operation      = s_tuser;
        in_word.presence       = s_tdata[0];
        in_word.id_bit         = s_tdata[1];
        in_word.complement_bit = s_tdata[2];
        expected_results.push_back(advance_search(in_word));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- verif/tb_onewire_rom_search_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_rom_search_engine_top
// stream-level regression of the rom search engine
// ----------------------------------------------------------------------------
// Drives a directed opening and then whole search episodes, each against a
// random bus image with chosen discrepancy positions, mixed with aborted, restarted
// and cut passes and random noise words. Input comes in bursts, the output
// side stalls on its own pattern with one long hold-off; the checker beside
// the engine predicts and compares every result word.
module tb_onewire_rom_search_engine_top;
  import ors_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned SEARCH_WORDS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_START   = 600;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_CLEAR;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned burst_left   = 0;
  int unsigned search_words = 0;
  int unsigned cycle_count  = 0;

  onewire_rom_search_engine_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  onewire_rom_search_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // sends one word, opening a new burst after a random gap when one runs out
  task automatic send_word(input logic [1:0] op, input logic pres, input logic idb,
                           input logic cmpb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b00000, cmpb, idb, pres};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic coin();
    return logic'($urandom_range(0, 1));
  endfunction

  // one search pass over a bus whose devices split at the marked positions
  task automatic run_pass(input logic [63:0] code, input logic [63:0] splits);
    int unsigned p;
    int unsigned cut;
    int unsigned mishap;
    cut    = $urandom_range(1, 64);
    mishap = $urandom_range(0, 39);
    send_word(OP_START, ($urandom_range(0, 24) != 0), coin(), coin());
    search_words++;
    for (p = 1; p <= 64; p++) begin
      if (p == cut && mishap == 0) begin
        send_word(OP_PAIR, coin(), 1'b1, 1'b1);
        search_words++;
        return;
      end
      if (p == cut && mishap == 1) begin
        // restart mid-pass
        send_word(OP_START, 1'b1, coin(), coin());
        search_words++;
        cut = 0;
        p   = 0;
        continue;
      end
      if (p == cut && mishap == 2) return;
      if (splits[p-1]) send_word(OP_PAIR, coin(), 1'b0, 1'b0);
      else send_word(OP_PAIR, coin(), code[p-1], ~code[p-1]);
      search_words++;
    end
  endtask

  task automatic run_episode();
    logic [63:0] code;
    logic [63:0] splits;
    int unsigned forks;
    int unsigned i;
    code   = {$urandom, $urandom};
    splits = '0;
    forks  = $urandom_range(0, 3);
    if ($urandom_range(0, 5) == 0) code[7:0] = 8'h00;
    for (i = 0; i < forks; i++) begin
      if ($urandom_range(0, 2) == 0) splits[$urandom_range(0, 7)] = 1'b1;
      else splits[$urandom_range(8, 63)] = 1'b1;
    end
    // one pass per leaf, and one more that should find the search exhausted
    repeat ((1 << forks) + 1) run_pass(code, splits);
    if (coin()) begin
      send_word(OP_CLEAR, coin(), coin(), coin());
      search_words++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_CLEAR,  1'b1, 1'b1, 1'b1);
    send_word(OP_PAIR,   1'b0, 1'b0, 1'b1);
    send_word(OP_UNUSED, 1'b1, 1'b1, 1'b1);
    send_word(OP_START,  1'b0, 1'b0, 1'b0);
    send_word(OP_START,  1'b1, 1'b0, 1'b0);
    send_word(OP_PAIR,   1'b0, 1'b0, 1'b1);
    send_word(OP_PAIR,   1'b0, 1'b1, 1'b0);
    send_word(OP_PAIR,   1'b0, 1'b0, 1'b0);
    send_word(OP_START,  1'b1, 1'b1, 1'b1);
    send_word(OP_PAIR,   1'b1, 1'b1, 1'b0);
    send_word(OP_PAIR,   1'b0, 1'b1, 1'b1);
    send_word(OP_PAIR,   1'b0, 1'b1, 1'b1);
    send_word(OP_UNUSED, 1'b0, 1'b0, 1'b0);
    send_word(OP_START,  1'b1, 1'b0, 1'b0);
    send_word(OP_PAIR,   1'b0, 1'b0, 1'b0);
    send_word(OP_CLEAR,  1'b0, 1'b0, 1'b0);

    while (search_words < SEARCH_WORDS) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(2'($urandom_range(0, 3)), coin(), coin(), coin());
          search_words++;
        end
      end else begin
        run_episode();
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: one long hold-off, otherwise ready follows one of four modes in turn
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        m_tready <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= rx_cycle[2];
        endcase
      end
      @(posedge clk);
      rx_cycle++;
    end
  end

endmodule

// ----- sim.f -----
rtl/ors_pkg.sv
rtl/ors_step.sv
rtl/onewire_rom_search_engine_top.sv
verif/onewire_rom_search_checker.sv
verif/tb_onewire_rom_search_engine_top.sv
